// File: rtl/asfbe_pkg.sv
// shared types and codes for the alu/shift/flags/branch execute unit
package asfbe_pkg;

	localparam int unsigned WordW = 16;
	localparam int unsigned ImmW  = 5;
	localparam int unsigned DispW = 8;

	typedef logic [WordW-1:0] word_t;

	// operation codes
	typedef enum logic [2:0] {
		ACT_ADD    = 3'd0,
		ACT_ADC    = 3'd1,
		ACT_SUB    = 3'd2,
		ACT_SBC    = 3'd3,
		ACT_AND    = 3'd4,
		ACT_OR     = 3'd5,
		ACT_ADDR   = 3'd6,
		ACT_BRANCH = 3'd7
	} action_t;

	// one-bit shifter modes for operand a
	typedef enum logic [1:0] {
		SH_NONE = 2'd0,
		SH_ASR  = 2'd1,
		SH_ROR  = 2'd2,
		SH_RRC  = 2'd3
	} shift_t;

	// branch condition codes
	typedef enum logic [3:0] {
		CC_AL = 4'd0,
		CC_NV = 4'd1,
		CC_HI = 4'd2,
		CC_LS = 4'd3,
		CC_CC = 4'd4,
		CC_CS = 4'd5,
		CC_NE = 4'd6,
		CC_EQ = 4'd7,
		CC_VC = 4'd8,
		CC_VS = 4'd9,
		CC_PL = 4'd10,
		CC_MI = 4'd11,
		CC_GE = 4'd12,
		CC_LT = 4'd13,
		CC_GT = 4'd14,
		CC_LE = 4'd15
	} cond_t;

	// condition flags, packed in nibble order n z v c
	typedef struct packed {
		logic n;
		logic z;
		logic v;
		logic c;
	} flags_t;

	// decoded request held in the input register
	typedef struct packed {
		action_t           action;
		word_t             operand_a;
		word_t             operand_b;
		logic              immediate_form;
		logic [ImmW-1:0]   imm_bits;
		shift_t            shift_kind;
		logic              set_flags;
		cond_t             cond_code;
		logic [DispW-1:0]  branch_disp;
	} req_t;

	// state updates produced by the alu for one request
	typedef struct packed {
		flags_t flags;
		logic   sc_we;
		logic   sc;
	} upd_t;

endpackage

// File: rtl/alu_shift_flags_branch_execute_unit.sv
// top level of the alu/shift/flags/branch execute unit
//
// Execute stage of a 16-bit processor. One request carries an instruction's
// operand values; one result carries the alu result, load/store address or
// sign-extended branch offset, the branch decision and the n z v c flags as
// they stand after the request.
// Channels: in_valid/in_ready take a request, out_valid/out_ready deliver
// its result. A request is taken on an edge where valid and ready are high.
// A request is taken into the input register, worked out by the shifter
// and alu in one pass, then captured in the result register, which drives
// the outputs; a stalled receiver holds it there. Throughput is one request
// per cycle while results are taken; the only loop is the flag and
// shifter carry registers, updated as a request leaves the input register,
// so the next request sees them at once.
// Reset clears both pipeline valids, the flags and the shifter carry.
// When the receiver stalls, the result register holds; the input register
// still takes one more request, then in_ready drops until out_ready returns.
module alu_shift_flags_branch_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	input  logic        immediate_form,
	input  logic [4:0]  imm_bits,
	input  logic [1:0]  shift_kind,
	input  logic        set_flags,
	input  logic [3:0]  cond_code,
	input  logic [7:0]  branch_disp,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_word,
	output logic        branch_taken,
	output logic [3:0]  flag_nibble
);

	asfbe_pkg::req_t   req_s1;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;
	asfbe_pkg::flags_t flags_q;
	logic              sc_q;
	asfbe_pkg::word_t  a_shifted;
	logic              sc_shifted;
	asfbe_pkg::word_t  alu_result;
	logic              alu_taken;
	asfbe_pkg::upd_t   upd;
	asfbe_pkg::word_t  result_s2;
	logic              taken_s2;
	asfbe_pkg::flags_t flags_s2;

	// handshake: the input register moves on when the result register frees up
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.action         <= asfbe_pkg::action_t'(action);
			req_s1.operand_a      <= operand_a;
			req_s1.operand_b      <= operand_b;
			req_s1.immediate_form <= immediate_form;
			req_s1.imm_bits       <= imm_bits;
			req_s1.shift_kind     <= asfbe_pkg::shift_t'(shift_kind);
			req_s1.set_flags      <= set_flags;
			req_s1.cond_code      <= asfbe_pkg::cond_t'(cond_code);
			req_s1.branch_disp    <= branch_disp;
		end
	end

	// shifter and alu
	asfbe_shifter u_shifter (
		.a      (req_s1.operand_a),
		.kind   (req_s1.shift_kind),
		.sc_in  (sc_q),
		.a_out  (a_shifted),
		.sc_out (sc_shifted)
	);

	asfbe_alu u_alu (
		.req        (req_s1),
		.a_shifted  (a_shifted),
		.sc_shifted (sc_shifted),
		.flags_in   (flags_q),
		.result     (alu_result),
		.taken      (alu_taken),
		.upd        (upd)
	);

	// flag and shifter carry state, written as a request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			sc_q    <= 1'b0;
		end else if (advance) begin
			flags_q <= upd.flags;
			if (upd.sc_we) begin
				sc_q <= upd.sc;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= alu_result;
			taken_s2  <= alu_taken;
			flags_s2  <= upd.flags;
		end
	end

	assign out_valid    = valid_s2;
	assign result_word  = result_s2;
	assign branch_taken = taken_s2;
	assign flag_nibble  = flags_s2;

endmodule

// File: rtl/asfbe_shifter.sv
// one-bit shifter for operand a with shifter carry out
module asfbe_shifter (
	input  asfbe_pkg::word_t  a,
	input  asfbe_pkg::shift_t kind,
	input  logic              sc_in,
	output asfbe_pkg::word_t  a_out,
	output logic              sc_out
);

	// shift right by one or pass unchanged; a bit shifted out goes to the shifter carry
	always_comb begin
		unique case (kind)
			asfbe_pkg::SH_NONE: begin
				a_out  = a;
				sc_out = 1'b0;
			end
			asfbe_pkg::SH_ASR: begin
				a_out  = {a[asfbe_pkg::WordW-1], a[asfbe_pkg::WordW-1:1]};
				sc_out = a[0];
			end
			asfbe_pkg::SH_ROR: begin
				a_out  = {a[0], a[asfbe_pkg::WordW-1:1]};
				sc_out = a[0];
			end
			asfbe_pkg::SH_RRC: begin
				a_out  = {sc_in, a[asfbe_pkg::WordW-1:1]};
				sc_out = a[0];
			end
			default: begin
				a_out  = a;
				sc_out = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/asfbe_alu.sv
// adder, logic ops, address, branch condition and flag update
module asfbe_alu (
	input  asfbe_pkg::req_t   req,
	input  asfbe_pkg::word_t  a_shifted,
	input  logic              sc_shifted,
	input  asfbe_pkg::flags_t flags_in,
	output asfbe_pkg::word_t  result,
	output logic              taken,
	output asfbe_pkg::upd_t   upd
);

	asfbe_pkg::word_t          a_eff;
	asfbe_pkg::word_t          b_eff;
	asfbe_pkg::word_t          bb;
	logic                      is_sub;
	logic                      cin;
	logic [asfbe_pkg::WordW:0] sum;
	asfbe_pkg::word_t          sum_w;
	logic                      lt;

	// operand selection: immediate form skips the shifter
	assign a_eff = req.immediate_form ? req.operand_a : a_shifted;
	assign b_eff = req.immediate_form
		? {{(asfbe_pkg::WordW-asfbe_pkg::ImmW){req.imm_bits[asfbe_pkg::ImmW-1]}}, req.imm_bits}
		: req.operand_b;

	// adder with carry in
	assign is_sub = (req.action == asfbe_pkg::ACT_SUB) || (req.action == asfbe_pkg::ACT_SBC);
	assign bb     = is_sub ? ~b_eff : b_eff;

	always_comb begin
		unique case (req.action)
			asfbe_pkg::ACT_ADC: cin = flags_in.c;
			asfbe_pkg::ACT_SUB: cin = 1'b1;
			asfbe_pkg::ACT_SBC: cin = ~flags_in.c;
			default:            cin = 1'b0;
		endcase
	end

	assign sum   = {1'b0, a_eff} + {1'b0, bb} + {{asfbe_pkg::WordW{1'b0}}, cin};
	assign sum_w = sum[asfbe_pkg::WordW-1:0];
	assign lt    = flags_in.n ^ flags_in.v;

	// result, branch decision and state updates
	always_comb begin
		result    = sum_w;
		taken     = 1'b0;
		upd.flags = flags_in;
		upd.sc_we = ~req.immediate_form && (req.action != asfbe_pkg::ACT_BRANCH);
		upd.sc    = sc_shifted;
		unique case (req.action)
			asfbe_pkg::ACT_ADD, asfbe_pkg::ACT_ADC,
			asfbe_pkg::ACT_SUB, asfbe_pkg::ACT_SBC: begin
				if (req.set_flags) begin
					upd.flags.n = sum_w[asfbe_pkg::WordW-1];
					upd.flags.z = (sum_w == '0);
					upd.flags.v = (a_eff[asfbe_pkg::WordW-1] ^ sum_w[asfbe_pkg::WordW-1])
						& (bb[asfbe_pkg::WordW-1] ^ sum_w[asfbe_pkg::WordW-1]);
					upd.flags.c = sum[asfbe_pkg::WordW] ^ is_sub;
				end
			end
			asfbe_pkg::ACT_AND, asfbe_pkg::ACT_OR: begin
				result = (req.action == asfbe_pkg::ACT_AND) ? (a_eff & b_eff) : (a_eff | b_eff);
				if (req.set_flags) begin
					upd.flags.n = result[asfbe_pkg::WordW-1];
					upd.flags.z = (result == '0);
					upd.flags.v = 1'b0;
					upd.flags.c = ~req.immediate_form && (req.shift_kind != asfbe_pkg::SH_NONE)
						&& sc_shifted;
				end
			end
			asfbe_pkg::ACT_ADDR: begin
				result = a_eff + b_eff;
			end
			asfbe_pkg::ACT_BRANCH: begin
				result = {{(asfbe_pkg::WordW-asfbe_pkg::DispW){req.branch_disp[asfbe_pkg::DispW-1]}},
					req.branch_disp};
				unique case (req.cond_code)
					asfbe_pkg::CC_AL: taken = 1'b1;
					asfbe_pkg::CC_NV: taken = 1'b0;
					asfbe_pkg::CC_HI: taken = ~(flags_in.c | flags_in.z);
					asfbe_pkg::CC_LS: taken = flags_in.c | flags_in.z;
					asfbe_pkg::CC_CC: taken = ~flags_in.c;
					asfbe_pkg::CC_CS: taken = flags_in.c;
					asfbe_pkg::CC_NE: taken = ~flags_in.z;
					asfbe_pkg::CC_EQ: taken = flags_in.z;
					asfbe_pkg::CC_VC: taken = ~flags_in.v;
					asfbe_pkg::CC_VS: taken = flags_in.v;
					asfbe_pkg::CC_PL: taken = ~flags_in.n;
					asfbe_pkg::CC_MI: taken = flags_in.n;
					asfbe_pkg::CC_GE: taken = ~lt;
					asfbe_pkg::CC_LT: taken = lt;
					asfbe_pkg::CC_GT: taken = ~(lt | flags_in.z);
					asfbe_pkg::CC_LE: taken = lt | flags_in.z;
					default:          taken = 1'b0;
				endcase
			end
			default: begin
				result = sum_w;
			end
		endcase
	end

endmodule

// File: rtl/asfbe_checker.sv
// port-level checker for the execute unit, bound to the top level
module asfbe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] result_word,
	input logic        branch_taken,
	input logic [3:0]  flag_nibble
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(result_word) && $stable(branch_taken)
			&& $stable(flag_nibble))
		else $error("result changed while stalled");

	// a receiver that takes results never blocks new requests
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("request blocked with receiver ready");

	// a taken request is expected at the output after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("request did not reach the output");

endmodule

bind alu_shift_flags_branch_execute_unit asfbe_checker u_asfbe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.result_word  (result_word),
	.branch_taken (branch_taken),
	.flag_nibble  (flag_nibble)
);
